// ===== rtl/wavp_pkg.sv =====
// Shared types and constants for the WAV header parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package wavp_pkg;

    // Chunk tags as read little-endian into a 32-bit word
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;

    // Fixed format checks and header sizes
    localparam logic [15:0] PCM_CODE      = 16'd1;
    localparam logic [15:0] PCM_BITS      = 16'd16;
    localparam logic [15:0] CHAN_MONO     = 16'd1;
    localparam logic [15:0] CHAN_STEREO   = 16'd2;
    localparam logic [31:0] FMT_BASE_SIZE = 32'd16;
    localparam logic [31:0] RIFF_HDR_LEN  = 32'd8;

    // Field widths in bytes
    localparam logic [2:0] HALF_BYTES = 3'd2;
    localparam logic [2:0] WORD_BYTES = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_NO_DATA   = 3'd3;
    localparam logic [2:0] ST_BAD_COMP  = 3'd4;
    localparam logic [2:0] ST_BAD_BITS  = 3'd5;
    localparam logic [2:0] ST_BAD_CHAN  = 3'd6;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_freq;
        logic [31:0] bytes_per_sec;
        logic [15:0] frame_size;
        logic [15:0] sample_bits;
        logic [31:0] data_offset;
        logic [31:0] data_length;
        logic [31:0] riff_total;
        logic        size_mismatch;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/wavp_in_reg.sv =====
// Input register for the WAV header parser: holds one byte beat.
// Depends on wavp_pkg for the beat type.
`default_nettype none

module wavp_in_reg
    import wavp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire in_beat_t in_beat,
    output logic          in_stall,
    input  wire logic     advance,
    output logic          beat_valid,
    output in_beat_t      beat
);

    logic     valid_reg;
    in_beat_t beat_reg;

    // Hold the beat while the parser cannot take it
    assign in_stall   = valid_reg && !advance;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wavp_parse.sv =====
// Parse step of the WAV header parser: phase, counters and format fields,
// updated once per byte. Depends on wavp_pkg for tags, codes and types.
`default_nettype none

module wavp_parse
    import wavp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step_en,
    input  wire in_beat_t beat,
    input  wire logic [31:0] file_length,
    output logic          res_valid,
    output result_t       res
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_DSIZE, PH_JSIZE, PH_SKIP,
        PH_FSIZE, PH_COMP, PH_CHAN, PH_RATE, PH_BRATE, PH_ALIGN, PH_BITS,
        PH_EXTRA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] gather_reg, gather_next;
    logic [32:0] skip_reg, skip_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] fsize_reg, fsize_next;
    logic [15:0] comp_reg, comp_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic        done_reg, done_next;

    logic        emit;
    logic [2:0]  emit_status;
    logic [31:0] emit_offset;
    logic [31:0] emit_length;

    // One byte of parsing
    always_comb
    begin
        logic        start_skip;
        logic        at_boundary;
        logic [32:0] skip_len;
        logic [31:0] word;
        logic [2:0]  need;
        logic [31:0] total;

        start_skip  = 1'b0;
        at_boundary = 1'b0;
        skip_len    = '0;
        word        = '0;
        need        = WORD_BYTES;
        total       = '0;

        emit        = 1'b0;
        emit_status = ST_OK;
        emit_offset = '0;
        emit_length = '0;

        // Restart on the first byte of a file
        if (beat.first_byte)
        begin
            phase_next  = PH_RIFF;
            pos_next    = '0;
            cnt_next    = '0;
            gather_next = '0;
            skip_next   = '0;
            limit_next  = '0;
            fsize_next  = '0;
            comp_next   = '0;
            chan_next   = '0;
            rate_next   = '0;
            brate_next  = '0;
            align_next  = '0;
            bits_next   = '0;
            done_next   = 1'b0;
        end
        else
        begin
            phase_next  = phase_reg;
            pos_next    = pos_reg;
            cnt_next    = cnt_reg;
            gather_next = gather_reg;
            skip_next   = skip_reg;
            limit_next  = limit_reg;
            fsize_next  = fsize_reg;
            comp_next   = comp_reg;
            chan_next   = chan_reg;
            rate_next   = rate_reg;
            brate_next  = brate_reg;
            align_next  = align_reg;
            bits_next   = bits_reg;
            done_next   = done_reg;
        end

        if (!done_next)
        begin
            pos_next = pos_next + 32'd1;

            if (phase_next == PH_SKIP)
            begin
                // Count down the skipped bytes
                if (skip_next != '0)
                begin
                    skip_next = skip_next - 33'd1;
                end
                at_boundary = (skip_next == '0);
            end
            else
            begin
                // Gather the field little-endian
                if (phase_next == PH_COMP || phase_next == PH_CHAN ||
                    phase_next == PH_ALIGN || phase_next == PH_BITS ||
                    phase_next == PH_EXTRA)
                begin
                    need = HALF_BYTES;
                end
                gather_next = gather_next
                    | ({24'd0, beat.data_byte} << {cnt_next[1:0], 3'b000});
                cnt_next = cnt_next + 3'd1;

                if (cnt_next >= need)
                begin
                    word        = gather_next;
                    gather_next = '0;
                    cnt_next    = '0;

                    unique case (phase_next)
                        PH_RIFF:
                        begin
                            if (word != TAG_RIFF)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_RIFF;
                            end
                            else
                            begin
                                phase_next = PH_RSIZE;
                            end
                        end
                        PH_RSIZE:
                        begin
                            limit_next = word + RIFF_HDR_LEN;
                            phase_next = PH_WAVE;
                        end
                        PH_WAVE:
                        begin
                            if (word != TAG_WAVE)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOT_WAVE;
                            end
                            else
                            begin
                                at_boundary = 1'b1;
                            end
                        end
                        PH_ID:
                        begin
                            if (word == TAG_DATA)
                            begin
                                phase_next = PH_DSIZE;
                            end
                            else if (word == TAG_FMT)
                            begin
                                phase_next = PH_FSIZE;
                            end
                            else
                            begin
                                phase_next = PH_JSIZE;
                            end
                        end
                        PH_DSIZE:
                        begin
                            // Validate format; first failing check wins
                            emit        = 1'b1;
                            emit_offset = pos_next;
                            emit_length = word;
                            if (comp_next != PCM_CODE)
                            begin
                                emit_status = ST_BAD_COMP;
                            end
                            else if (bits_next != PCM_BITS)
                            begin
                                emit_status = ST_BAD_BITS;
                            end
                            else if (chan_next != CHAN_MONO && chan_next != CHAN_STEREO)
                            begin
                                emit_status = ST_BAD_CHAN;
                            end
                            else
                            begin
                                emit_status = ST_OK;
                            end
                        end
                        PH_JSIZE:
                        begin
                            // Skip an unknown chunk, padded to even
                            start_skip = 1'b1;
                            skip_len   = {1'b0, word} + {32'd0, word[0]};
                        end
                        PH_FSIZE:
                        begin
                            fsize_next = word;
                            phase_next = PH_COMP;
                        end
                        PH_COMP:
                        begin
                            comp_next  = word[15:0];
                            phase_next = PH_CHAN;
                        end
                        PH_CHAN:
                        begin
                            chan_next  = word[15:0];
                            phase_next = PH_RATE;
                        end
                        PH_RATE:
                        begin
                            rate_next  = word;
                            phase_next = PH_BRATE;
                        end
                        PH_BRATE:
                        begin
                            brate_next = word;
                            phase_next = PH_ALIGN;
                        end
                        PH_ALIGN:
                        begin
                            align_next = word[15:0];
                            phase_next = PH_BITS;
                        end
                        PH_BITS:
                        begin
                            bits_next = word[15:0];
                            if (fsize_next > FMT_BASE_SIZE)
                            begin
                                phase_next = PH_EXTRA;
                            end
                            else
                            begin
                                start_skip = 1'b1;
                                skip_len   = {32'd0, fsize_next[0]};
                            end
                        end
                        PH_EXTRA:
                        begin
                            // Skip the extension and the odd pad byte
                            start_skip = 1'b1;
                            skip_len   = {1'b0, word} + {32'd0, fsize_next[0]};
                        end
                        default:
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NO_DATA;
                        end
                    endcase
                end
            end

            // Load a skip; an empty one ends the chunk at once
            if (start_skip)
            begin
                skip_next = skip_len;
                if (skip_len == '0)
                begin
                    at_boundary = 1'b1;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end

            // Chunk boundary: walk on or end with no data chunk
            if (at_boundary)
            begin
                if (pos_next >= limit_next)
                begin
                    emit        = 1'b1;
                    emit_status = ST_NO_DATA;
                end
                else
                begin
                    phase_next = PH_ID;
                end
            end

            if (emit)
            begin
                done_next = 1'b1;
            end
        end

        // Build the result beat
        total = (emit_status == ST_NOT_RIFF) ? '0 : limit_next;
        res.status        = emit_status;
        res.format_tag    = comp_next;
        res.channel_count = chan_next;
        res.sample_freq   = rate_next;
        res.bytes_per_sec = brate_next;
        res.frame_size    = align_next;
        res.sample_bits   = bits_next;
        res.data_offset   = emit_offset;
        res.data_length   = emit_length;
        res.riff_total    = total;
        res.size_mismatch = (emit_status != ST_NOT_RIFF) && (total != file_length);
    end

    assign res_valid = step_en && emit;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            gather_reg <= '0;
            skip_reg   <= '0;
            limit_reg  <= '0;
            fsize_reg  <= '0;
            comp_reg   <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            brate_reg  <= '0;
            align_reg  <= '0;
            bits_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            gather_reg <= gather_next;
            skip_reg   <= skip_next;
            limit_reg  <= limit_next;
            fsize_reg  <= fsize_next;
            comp_reg   <= comp_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            brate_reg  <= brate_next;
            align_reg  <= align_next;
            bits_reg   <= bits_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wavp_out_reg.sv =====
// Result register for the WAV header parser: holds one result beat.
// Depends on wavp_pkg for the result type.
`default_nettype none

module wavp_out_reg
    import wavp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         take,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_res
);

    logic    valid_reg;
    result_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign take      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wav_header_parser_unit.sv =====
// WAV header parser, top level: input register, parse step, result register.
// A byte held in the input register is parsed combinationally and its result
// registered in the result register. Throughput: one byte per cycle, set by
// the combinational parse step; stalls only while the result is held.
// Reset (rst_n, async, active low) clears the parse state and file_length and
// empties both registers; a file may start right after reset.
`default_nettype none

module wav_header_parser_unit
    import wavp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // Byte input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    // Result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [15:0]      format_tag,
    output logic [15:0]      channel_count,
    output logic [31:0]      sample_freq,
    output logic [31:0]      bytes_per_sec,
    output logic [15:0]      frame_size,
    output logic [15:0]      sample_bits,
    output logic [31:0]      data_offset,
    output logic [31:0]      data_length,
    output logic [31:0]      riff_total,
    output logic             size_mismatch
);

    logic [31:0] file_length_reg;
    in_beat_t    in_beat;
    in_beat_t    beat;
    logic        beat_valid;
    logic        take;
    logic        advance;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            file_length_reg <= cfg_data;
        end
    end

    assign in_beat.data_byte  = data_byte;
    assign in_beat.first_byte = first_byte;

    // Step the parser when a byte is held and the result slot is free
    assign advance = beat_valid && take;

    wavp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_beat    (in_beat),
        .in_stall   (in_stall),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    wavp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .beat        (beat),
        .file_length (file_length_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    wavp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // Unpack the result beat
    assign status        = out_res.status;
    assign format_tag    = out_res.format_tag;
    assign channel_count = out_res.channel_count;
    assign sample_freq   = out_res.sample_freq;
    assign bytes_per_sec = out_res.bytes_per_sec;
    assign frame_size    = out_res.frame_size;
    assign sample_bits   = out_res.sample_bits;
    assign data_offset   = out_res.data_offset;
    assign data_length   = out_res.data_length;
    assign riff_total    = out_res.riff_total;
    assign size_mismatch = out_res.size_mismatch;

endmodule

`default_nettype wire
